FILE: rtl/mrtu_pkg.sv
// Package for the Modbus RTU frame receiver: word types, status codes,
// reset values and the CRC-16 byte update. No dependencies.
package mrtu_pkg;

	localparam int BUF_DEPTH_DEF = 64;

	localparam logic [7:0]  OWN_ADDRESS_RST = 8'd1;
	localparam logic [6:0]  PAYLOAD_LENGTH_RST = 7'd4;
	localparam logic [63:0] FUNCTION_MASK_RST = 64'd72;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [1:0] REG_OWN_ADDRESS = 2'd0;
	localparam logic [1:0] REG_PAYLOAD_LENGTH = 2'd1;
	localparam logic [1:0] REG_FUNCTION_MASK = 2'd2;

	localparam logic [1:0] ST_BUSY = 2'd0;
	localparam logic [1:0] ST_GOOD = 2'd1;
	localparam logic [1:0] ST_CRC_ERR = 2'd2;
	localparam logic [1:0] ST_REJECT = 2'd3;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_RESYNC = 1'b1;

	typedef struct packed {
		logic       op;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] func_code;
		logic [7:0] data_byte;
		logic [5:0] data_index;
		logic [6:0] data_count;
		logic       last;
	} result_t;

	typedef struct packed {
		logic       drain;
		logic [1:0] status;
		logic [7:0] func_code;
		logic [6:0] count;
		logic       bank;
	} cmd_t;

	typedef struct packed {
		logic       done;
		logic       bank;
	} drain_done_t;

	function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (r[0]) begin
				r = (r >> 1) ^ CRC_POLY;
			end else begin
				r = r >> 1;
			end
		end
		return r;
	endfunction

endpackage

FILE: rtl/mrtu_front.sv
// Front end of the Modbus RTU frame receiver: configuration registers, frame
// parser, CRC tracking and payload writes. Depends on mrtu_pkg.
module mrtu_front #(
	parameter int BUF_DEPTH = mrtu_pkg::BUF_DEPTH_DEF,
	localparam int IDX_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [63:0]          cfg_data,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  mrtu_pkg::item_t      item,
	input  logic                 q_full,
	output logic                 q_push,
	output mrtu_pkg::cmd_t       q_cmd,
	input  mrtu_pkg::drain_done_t drain_done,
	output logic                 wr_en,
	output logic [IDX_W:0]       wr_addr,
	output logic [7:0]           wr_data
);

	typedef enum logic [4:0] {
		PH_HUNT  = 5'b00001,
		PH_FUNC  = 5'b00010,
		PH_DATA  = 5'b00100,
		PH_CRCLO = 5'b01000,
		PH_CRCHI = 5'b10000
	} phase_t;

	localparam logic [6:0] DEPTH7 = 7'(BUF_DEPTH);

	logic [7:0]  own_address_q;
	logic [6:0]  payload_length_q;
	logic [63:0] function_mask_q;

	phase_t      phase_q, phase_d;
	logic [15:0] crc_q, crc_d;
	logic [15:0] chk_q, chk_d;
	logic [7:0]  held_q, held_d;
	logic [6:0]  cnt_q, cnt_d;
	logic        wb_q, wb_d;
	logic [1:0]  busy_q;
	logic        set_busy;
	logic        accept, blocked, reject;
	logic [6:0]  eff_len;
	logic [7:0]  b;

	assign b = item.rx_byte;
	assign blocked = (item.op == mrtu_pkg::OP_BYTE) && (phase_q == PH_DATA) && busy_q[wb_q];
	assign item_stall = q_full || blocked;
	assign accept = item_valid && !item_stall;
	assign q_push = accept;

	always_comb begin
		if (payload_length_q == 7'd0) begin
			eff_len = 7'd1;
		end else if (payload_length_q > DEPTH7) begin
			eff_len = DEPTH7;
		end else begin
			eff_len = payload_length_q;
		end
	end

	always_comb begin
		phase_d = phase_q;
		crc_d = crc_q;
		chk_d = chk_q;
		held_d = held_q;
		cnt_d = cnt_q;
		wb_d = wb_q;
		set_busy = 1'b0;
		reject = 1'b0;
		wr_en = 1'b0;
		wr_addr = {wb_q, cnt_q[IDX_W-1:0]};
		wr_data = b;
		q_cmd.drain = 1'b0;
		q_cmd.status = mrtu_pkg::ST_BUSY;
		q_cmd.count = 7'd0;
		q_cmd.bank = wb_q;
		if (accept) begin
			if (item.op == mrtu_pkg::OP_RESYNC) begin
				phase_d = PH_HUNT;
			end else begin
				case (phase_q)
					PH_HUNT: begin
						if (b == own_address_q) begin
							phase_d = PH_FUNC;
							held_d = 8'd0;
							cnt_d = 7'd0;
							crc_d = mrtu_pkg::crc_feed(mrtu_pkg::CRC_INIT, b);
						end
					end
					PH_FUNC: begin
						if (b[7:6] != 2'b00 || !function_mask_q[b[5:0]]) begin
							phase_d = PH_HUNT;
							reject = 1'b1;
							q_cmd.status = mrtu_pkg::ST_REJECT;
						end else begin
							held_d = b;
							phase_d = PH_DATA;
							crc_d = mrtu_pkg::crc_feed(crc_q, b);
						end
					end
					PH_DATA: begin
						wr_en = (cnt_q < DEPTH7);
						cnt_d = cnt_q + 7'd1;
						crc_d = mrtu_pkg::crc_feed(crc_q, b);
						if (cnt_d >= eff_len) begin
							phase_d = PH_CRCLO;
						end
					end
					PH_CRCLO: begin
						chk_d = crc_q ^ {8'h00, b};
						phase_d = PH_CRCHI;
					end
					PH_CRCHI: begin
						chk_d = chk_q ^ {b, 8'h00};
						phase_d = PH_HUNT;
						if (chk_d == 16'd0 && cnt_q != 7'd0) begin
							q_cmd.drain = 1'b1;
							q_cmd.status = mrtu_pkg::ST_GOOD;
							q_cmd.count = (cnt_q > DEPTH7) ? DEPTH7 : cnt_q;
							set_busy = 1'b1;
							wb_d = ~wb_q;
						end else begin
							q_cmd.status = mrtu_pkg::ST_CRC_ERR;
						end
					end
					default: begin
						phase_d = PH_HUNT;
					end
				endcase
			end
		end
		q_cmd.func_code = reject ? b : held_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q <= mrtu_pkg::OWN_ADDRESS_RST;
			payload_length_q <= mrtu_pkg::PAYLOAD_LENGTH_RST;
			function_mask_q <= mrtu_pkg::FUNCTION_MASK_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				mrtu_pkg::REG_OWN_ADDRESS: own_address_q <= cfg_data[7:0];
				mrtu_pkg::REG_PAYLOAD_LENGTH: payload_length_q <= cfg_data[6:0];
				mrtu_pkg::REG_FUNCTION_MASK: function_mask_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			crc_q <= mrtu_pkg::CRC_INIT;
			chk_q <= 16'd0;
			held_q <= 8'd0;
			cnt_q <= 7'd0;
			wb_q <= 1'b0;
			busy_q <= 2'b00;
		end else begin
			phase_q <= phase_d;
			crc_q <= crc_d;
			chk_q <= chk_d;
			held_q <= held_d;
			cnt_q <= cnt_d;
			wb_q <= wb_d;
			for (int i = 0; i < 2; i++) begin
				busy_q[i] <= (busy_q[i] && !(drain_done.done && drain_done.bank == 1'(i)))
					|| (set_busy && wb_q == 1'(i));
			end
		end
	end

endmodule

FILE: rtl/mrtu_cmd_fifo.sv
// Two-entry command queue between the parser and the result sequencer of the
// Modbus RTU frame receiver. Depends on mrtu_pkg.
module mrtu_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mrtu_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output mrtu_pkg::cmd_t head,
	output logic           empty
);

	mrtu_pkg::cmd_t entry_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign head = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop && !empty) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push && !full) - 2'(pop && !empty);
		end
	end

endmodule

FILE: rtl/mrtu_back.sv
// Result sequencer of the Modbus RTU frame receiver: two-bank payload memory,
// drain of good frames and the output register. Depends on mrtu_pkg.
module mrtu_back #(
	parameter int BUF_DEPTH = mrtu_pkg::BUF_DEPTH_DEF,
	localparam int IDX_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [IDX_W:0]        wr_addr,
	input  logic [7:0]            wr_data,
	input  logic                  q_empty,
	input  mrtu_pkg::cmd_t        q_head,
	output logic                  q_pop,
	output mrtu_pkg::drain_done_t drain_done,
	output logic                  result_valid,
	input  logic                  result_stall,
	output mrtu_pkg::result_t     result
);

	typedef enum logic [2:0] {
		BK_IDLE = 3'b001,
		BK_READ = 3'b010,
		BK_LOAD = 3'b100
	} back_state_t;

	logic [7:0]  mem [2**(IDX_W+1)];
	logic [7:0]  rd_data_q;
	logic        rd_en;

	back_state_t state_q;
	logic [5:0]  k_q;
	logic [7:0]  func_q;
	logic [6:0]  count_q;
	logic        bank_q;
	logic        out_valid_q;
	logic        slot_free;
	logic        last_k;
	logic        load_out;

	assign slot_free = !out_valid_q || !result_stall;
	assign rd_en = (state_q == BK_READ);
	assign last_k = ({1'b0, k_q} + 7'd1 == count_q);
	assign q_pop = (state_q == BK_IDLE) && !q_empty && (q_head.drain || slot_free);
	assign load_out = ((state_q == BK_IDLE) && q_pop && !q_head.drain)
		|| ((state_q == BK_LOAD) && slot_free);
	assign drain_done.done = (state_q == BK_LOAD) && slot_free && last_k;
	assign drain_done.bank = bank_q;
	assign result_valid = out_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[{bank_q, k_q[IDX_W-1:0]}];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_IDLE && q_pop && !q_head.drain) begin
			result.status <= q_head.status;
			result.func_code <= q_head.func_code;
			result.data_byte <= 8'd0;
			result.data_index <= 6'd0;
			result.data_count <= 7'd0;
			result.last <= 1'b1;
		end else if (state_q == BK_LOAD && slot_free) begin
			result.status <= mrtu_pkg::ST_GOOD;
			result.func_code <= func_q;
			result.data_byte <= rd_data_q;
			result.data_index <= k_q;
			result.data_count <= count_q;
			result.last <= last_k;
		end
		if (q_pop && q_head.drain) begin
			func_q <= q_head.func_code;
			count_q <= q_head.count;
			bank_q <= q_head.bank;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			k_q <= 6'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (slot_free) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				BK_IDLE: begin
					if (q_pop && q_head.drain) begin
						k_q <= 6'd0;
						state_q <= BK_READ;
					end
				end
				BK_READ: begin
					state_q <= BK_LOAD;
				end
				BK_LOAD: begin
					if (slot_free) begin
						if (last_k) begin
							state_q <= BK_IDLE;
						end else begin
							k_q <= k_q + 6'd1;
							state_q <= BK_READ;
						end
					end
				end
				default: begin
					state_q <= BK_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/modbus_rtu_frame_receiver_top.sv
// Modbus RTU frame receiver: one received word enters per cycle while the
// two-entry command queue has room, and every word causes at least one result
// word. A good frame drains its payload one result at a time, each through a read
// state and then a load state on the registered read port of the payload memory.
// While a drain runs the back end takes no commands, so the front accepts at most
// two more words before the queue fills, and the input then stalls until the drain
// ends and the back end takes commands again. The memory has two banks, so a
// payload byte of the next frame never overwrites a payload that is still
// draining; a byte that would land in the draining bank stalls the input. The
// payload memory needs no clearing after reset.
// Depends on mrtu_pkg, mrtu_front, mrtu_cmd_fifo and mrtu_back.
module modbus_rtu_frame_receiver_top #(
	parameter int BUF_DEPTH = mrtu_pkg::BUF_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [63:0]       cfg_data,
	input  logic              item_valid,
	output logic              item_stall,
	input  mrtu_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output mrtu_pkg::result_t result
);

	localparam int IDX_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

	logic                  q_push, q_full, q_pop, q_empty;
	mrtu_pkg::cmd_t        q_cmd, q_head;
	mrtu_pkg::drain_done_t drain_done;
	logic                  wr_en;
	logic [IDX_W:0]        wr_addr;
	logic [7:0]            wr_data;

	mrtu_front #(.BUF_DEPTH(BUF_DEPTH)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.q_full(q_full),
		.q_push(q_push),
		.q_cmd(q_cmd),
		.drain_done(drain_done),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	mrtu_cmd_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_cmd(q_cmd),
		.full(q_full),
		.pop(q_pop),
		.head(q_head),
		.empty(q_empty)
	);

	mrtu_back #(.BUF_DEPTH(BUF_DEPTH)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.q_empty(q_empty),
		.q_head(q_head),
		.q_pop(q_pop),
		.drain_done(drain_done),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

endmodule

FILE: rtl/mrtu_checker.sv
// Port-level checks for the Modbus RTU frame receiver and the bind that
// attaches them to the top level. Depends on mrtu_pkg.
module mrtu_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              result_valid,
	input logic              result_stall,
	input mrtu_pkg::result_t result
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("Stalled result word changed.");

	a_good_index: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == mrtu_pkg::ST_GOOD
		|-> result.data_count != 7'd0 && {1'b0, result.data_index} < result.data_count)
		else $error("Good frame word has an index outside its count.");

	a_good_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == mrtu_pkg::ST_GOOD
		|-> result.last == ({1'b0, result.data_index} + 7'd1 == result.data_count))
		else $error("Good frame word has a wrong last flag.");

	a_status_word: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status != mrtu_pkg::ST_GOOD
		|-> result.last && result.data_byte == 8'd0 && result.data_index == 6'd0
			&& result.data_count == 7'd0)
		else $error("Status word carries payload fields or is not last.");

endmodule

bind modbus_rtu_frame_receiver_top mrtu_checker u_mrtu_checker (.*);

FILE: test/modbus_rtu_frame_receiver_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for modbus_rtu_frame_receiver_top. It sends framed and noisy byte
// streams with random idling on both sides and checks every result word against a frame parser
// kept in a scoreboard class. Depends on mrtu_pkg and the receiver RTL.

typedef enum logic [2:0] {PH_HUNT, PH_FUNC, PH_DATA, PH_CRC_LO, PH_CRC_HI} sb_phase_t;

class frame_scoreboard;
	logic [7:0]        own_addr;
	logic [6:0]        pay_len;
	logic [63:0]       func_mask;
	sb_phase_t         phase;
	logic [15:0]       crc_run;
	logic [15:0]       crc_cmp;
	logic [7:0]        func_held;
	logic [6:0]        byte_cnt;
	logic [7:0]        payload [64];
	mrtu_pkg::result_t due_words [$];
	int                errors;

	function new();
		own_addr = mrtu_pkg::OWN_ADDRESS_RST;
		pay_len = mrtu_pkg::PAYLOAD_LENGTH_RST;
		func_mask = mrtu_pkg::FUNCTION_MASK_RST;
		phase = PH_HUNT;
		crc_run = mrtu_pkg::CRC_INIT;
		crc_cmp = '0;
		func_held = '0;
		byte_cnt = '0;
		errors = 0;
		foreach (payload[i]) payload[i] = '0;
	endfunction

	static function logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
		logic [15:0] r;
		logic        fb;
		r = c ^ {8'h00, b};
		repeat (8) begin
			fb = r[0];
			r = {1'b0, r[15:1]};
			if (fb) begin
				r = r ^ 16'hA001;
			end
		end
		return r;
	endfunction

	function int frame_len();
		if (pay_len == 7'd0) begin
			return 1;
		end
		return (pay_len > 7'd64) ? 64 : int'(pay_len);
	endfunction

	function void write_reg(logic [1:0] idx, logic [63:0] d);
		case (idx)
			mrtu_pkg::REG_OWN_ADDRESS: own_addr = d[7:0];
			mrtu_pkg::REG_PAYLOAD_LENGTH: pay_len = d[6:0];
			mrtu_pkg::REG_FUNCTION_MASK: func_mask = d;
			default: ;
		endcase
	endfunction

	function void add_word(logic [1:0] st, logic [7:0] fc, logic [7:0] db, logic [5:0] di,
			logic [6:0] dc, logic lst);
		mrtu_pkg::result_t r;
		r.status = st;
		r.func_code = fc;
		r.data_byte = db;
		r.data_index = di;
		r.data_count = dc;
		r.last = lst;
		due_words.push_back(r);
	endfunction

	function void note_input(mrtu_pkg::item_t w);
		int n;
		int k;
		if (w.op == mrtu_pkg::OP_RESYNC) begin
			phase = PH_HUNT;
			add_word(mrtu_pkg::ST_BUSY, func_held, 8'd0, 6'd0, 7'd0, 1'b1);
			return;
		end
		case (phase)
			PH_HUNT: begin
				if (w.rx_byte == own_addr) begin
					phase = PH_FUNC;
					func_held = 8'd0;
					byte_cnt = 7'd0;
					crc_run = crc_next(mrtu_pkg::CRC_INIT, w.rx_byte);
				end
			end
			PH_FUNC: begin
				if (w.rx_byte > 8'd63 || !func_mask[w.rx_byte[5:0]]) begin
					phase = PH_HUNT;
					add_word(mrtu_pkg::ST_REJECT, w.rx_byte, 8'd0, 6'd0, 7'd0, 1'b1);
					return;
				end
				func_held = w.rx_byte;
				phase = PH_DATA;
				crc_run = crc_next(crc_run, w.rx_byte);
			end
			PH_DATA: begin
				if (byte_cnt < 7'd64) begin
					payload[byte_cnt[5:0]] = w.rx_byte;
				end
				byte_cnt = byte_cnt + 7'd1;
				crc_run = crc_next(crc_run, w.rx_byte);
				if (int'(byte_cnt) >= frame_len()) begin
					phase = PH_CRC_LO;
				end
			end
			PH_CRC_LO: begin
				crc_cmp = crc_run ^ {8'h00, w.rx_byte};
				phase = PH_CRC_HI;
			end
			PH_CRC_HI: begin
				crc_cmp = crc_cmp ^ {w.rx_byte, 8'h00};
				phase = PH_HUNT;
				if (crc_cmp == 16'd0 && byte_cnt >= 7'd1) begin
					n = (byte_cnt > 7'd64) ? 64 : int'(byte_cnt);
					for (k = 0; k < n; k++) begin
						add_word(mrtu_pkg::ST_GOOD, func_held, payload[k], 6'(k), 7'(n),
							k == n - 1);
					end
					return;
				end
				add_word(mrtu_pkg::ST_CRC_ERR, func_held, 8'd0, 6'd0, 7'd0, 1'b1);
				return;
			end
			default: phase = PH_HUNT;
		endcase
		add_word(mrtu_pkg::ST_BUSY, func_held, 8'd0, 6'd0, 7'd0, 1'b1);
	endfunction

	function void check_result(mrtu_pkg::result_t got);
		mrtu_pkg::result_t want;
		if (due_words.size() == 0) begin
			errors++;
			if (errors <= 10) begin
				$display("unexpected word: st=%0d fc=%02h db=%02h di=%0d dc=%0d last=%0d",
					got.status, got.func_code, got.data_byte, got.data_index, got.data_count,
					got.last);
			end
			return;
		end
		want = due_words.pop_front();
		if (got !== want) begin
			errors++;
			if (errors <= 10) begin
				$display("mismatch at %0t: expected st=%0d fc=%02h db=%02h di=%0d dc=%0d last=%0d",
					$realtime, want.status, want.func_code, want.data_byte, want.data_index,
					want.data_count, want.last);
				$display("                 actual   st=%0d fc=%02h db=%02h di=%0d dc=%0d last=%0d",
					got.status, got.func_code, got.data_byte, got.data_index, got.data_count,
					got.last);
			end
		end
	endfunction

	function int pending();
		return due_words.size();
	endfunction
endclass

module modbus_rtu_frame_receiver_top_tb;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [1:0]        cfg_index = mrtu_pkg::REG_OWN_ADDRESS;
	logic [63:0]       cfg_data = '0;
	logic              item_valid = 1'b0;
	logic              item_stall;
	mrtu_pkg::item_t   item = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	mrtu_pkg::result_t result;

	frame_scoreboard sb;
	mrtu_pkg::item_t word_q [$];
	bit              hold_off_req = 1'b0;
	bit              steady = 1'b0;
	int              watchdog = 0;

	modbus_rtu_frame_receiver_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always #6 clk = ~clk;

	function int next_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 50) begin
			return 0;
		end
		if (r < 85) begin
			return $urandom_range(1, 3);
		end
		if (r < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	function mrtu_pkg::item_t byte_word(logic [7:0] b);
		mrtu_pkg::item_t w;
		w.op = mrtu_pkg::OP_BYTE;
		w.rx_byte = b;
		return w;
	endfunction

	function mrtu_pkg::item_t resync_word();
		mrtu_pkg::item_t w;
		w.op = mrtu_pkg::OP_RESYNC;
		w.rx_byte = 8'($urandom);
		return w;
	endfunction

	function logic [7:0] enabled_func();
		int s;
		int i;
		s = $urandom_range(0, 63);
		for (i = 0; i < 64; i++) begin
			if (sb.func_mask[(s + i) % 64]) begin
				return 8'((s + i) % 64);
			end
		end
		return 8'd0;
	endfunction

	// Queues one frame for the current address; a bad CRC flips one bit of the check value.
	function void push_frame(logic [7:0] fc, int len, bit bad_crc);
		logic [15:0] c;
		logic [7:0]  b;
		int          i;
		word_q.push_back(byte_word(sb.own_addr));
		c = sb.crc_next(mrtu_pkg::CRC_INIT, sb.own_addr);
		word_q.push_back(byte_word(fc));
		c = sb.crc_next(c, fc);
		for (i = 0; i < len; i++) begin
			b = 8'($urandom);
			word_q.push_back(byte_word(b));
			c = sb.crc_next(c, b);
		end
		if (bad_crc) begin
			c = c ^ (16'd1 << $urandom_range(0, 15));
		end
		word_q.push_back(byte_word(c[7:0]));
		word_q.push_back(byte_word(c[15:8]));
	endfunction

	task automatic send_all();
		mrtu_pkg::item_t w;
		int              g;
		while (word_q.size() != 0) begin
			w = word_q.pop_front();
			g = next_gap();
			if (g > 0) begin
				item_valid <= 1'b0;
				repeat (g) @(negedge clk);
			end
			item <= w;
			item_valid <= 1'b1;
			do @(posedge clk); while (item_stall);
			sb.note_input(w);
			@(negedge clk);
		end
		item_valid <= 1'b0;
	endtask

	task automatic set_config(logic [7:0] addr, logic [6:0] len, logic [63:0] mask);
		while (sb.pending() != 0) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= mrtu_pkg::REG_OWN_ADDRESS;
		cfg_data <= {56'd0, addr};
		@(negedge clk);
		sb.write_reg(mrtu_pkg::REG_OWN_ADDRESS, {56'd0, addr});
		cfg_index <= mrtu_pkg::REG_PAYLOAD_LENGTH;
		cfg_data <= {57'd0, len};
		@(negedge clk);
		sb.write_reg(mrtu_pkg::REG_PAYLOAD_LENGTH, {57'd0, len});
		cfg_index <= mrtu_pkg::REG_FUNCTION_MASK;
		cfg_data <= mask;
		@(negedge clk);
		sb.write_reg(mrtu_pkg::REG_FUNCTION_MASK, mask);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic run_phase(logic [7:0] addr, logic [6:0] len, logic [63:0] mask, int n_items,
			bit hold);
		int pick;
		int flen;
		int i;
		set_config(addr, len, mask);
		steady = ($urandom_range(0, 3) == 0);
		flen = sb.frame_len();
		word_q.push_back(resync_word());
		while (word_q.size() < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				push_frame(enabled_func(), flen, 1'b0);
			end else if (pick < 70) begin
				push_frame(enabled_func(), flen, 1'b1);
			end else if (pick < 78) begin
				push_frame(8'($urandom), flen, 1'b0);
			end else if (pick < 86) begin
				word_q.push_back(byte_word(sb.own_addr));
				word_q.push_back(byte_word(enabled_func()));
				for (i = $urandom_range(0, flen - 1); i > 0; i--) begin
					word_q.push_back(byte_word(8'($urandom)));
				end
				word_q.push_back(resync_word());
			end else if (pick < 94) begin
				for (i = $urandom_range(1, 3); i > 0; i--) begin
					word_q.push_back(byte_word(8'($urandom)));
				end
				if ($urandom_range(0, 1) == 0) begin
					word_q.push_back(resync_word());
				end
			end else begin
				word_q.push_back(resync_word());
			end
		end
		if (hold) begin
			@(posedge clk);
			hold_off_req = 1'b1;
			@(negedge clk);
		end
		send_all();
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			sb.check_result(result);
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
			watchdog <= 0;
		end else begin
			watchdog <= watchdog + 1;
		end
		if (watchdog >= WATCHDOG_LIMIT) begin
			$display("modbus_rtu_frame_receiver_top test failed");
			$finish;
		end
	end

	initial begin
		int hold_left;
		int stall_left;
		hold_left = 0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
				stall_left = next_gap();
			end
		end
	end

	initial begin
		sb = new();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: a resync while hunting, a foreign address, a good frame, function
		// codes above 63 and with a clear mask bit, and a frame with a broken CRC.
		word_q.push_back(resync_word());
		word_q.push_back(byte_word(8'h00));
		push_frame(8'd3, 4, 1'b0);
		word_q.push_back(byte_word(sb.own_addr));
		word_q.push_back(byte_word(8'h40));
		word_q.push_back(byte_word(sb.own_addr));
		word_q.push_back(byte_word(8'hFF));
		word_q.push_back(byte_word(sb.own_addr));
		word_q.push_back(byte_word(8'h00));
		push_frame(8'd6, 4, 1'b1);
		send_all();

		run_phase(8'h00, 7'd0, '1, 25, 1'b0);
		run_phase(8'hFF, 7'd1, {1'b1, 62'd0, 1'b1}, 25, 1'b0);
		run_phase(8'($urandom), 7'd64, {$urandom, $urandom}, 30, 1'b0);
		run_phase(8'($urandom), 7'($urandom_range(2, 8)), {$urandom, $urandom}, 30, 1'b1);
		run_phase(8'($urandom), 7'd127, '1, 30, 1'b0);
		run_phase(8'($urandom), 7'($urandom_range(1, 6)), 64'd0, 8, 1'b0);
		run_phase(8'($urandom), 7'($urandom_range(1, 8)), {$urandom, $urandom}, 15, 1'b0);
		run_phase(8'($urandom), 7'($urandom_range(1, 8)), {$urandom, $urandom}, 15, 1'b0);

		while (sb.pending() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("modbus_rtu_frame_receiver_top test passed");
		end else begin
			$display("modbus_rtu_frame_receiver_top test failed");
		end
		$finish;
	end
endmodule
